// ===== hw/rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary max-heap priority queue:
// operation and status codes, heap entry layout, sequencer states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Default number of heap slots
  localparam int unsigned CAPACITY_DEF = 64;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One heap entry: signed 16.16 priority plus payload
  typedef struct packed {
    logic signed [31:0] pri;
    logic [31:0]        pay;
  } entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_TAKE,
    S_DN_CHK,
    S_DN_CMP,
    S_HEAD_RD,
    S_RESULT
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    set_status;  // latch status, zero popped pair
    status_e status;
    logic    cap_push;    // capture pushed pair, grow count
    logic    clr_fill;    // empty the queue
    logic    rd_parent;   // read parent of current slot
    logic    rd_ends;     // read root and last slot
    logic    rd_kids;     // read both children of current slot
    logic    rd_root;     // read root for the head report
    logic    up_step;     // move parent down into current slot
    logic    dn_step;     // move chosen child up into current slot
    logic    take;        // keep root as popped, last as moving entry
    logic    place;       // write moving entry into current slot
    logic    load_out;    // fill the result register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic n_root;
    logic up_go;
    logic dn_more;
    logic dn_go;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/binary_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-priority queue of (priority, payload) pairs kept as a binary heap.
// ----------------------------------------------------------------------------
// Each input item is a push, a pop of the highest entry, or a clear; each
// produces exactly one result with status, popped pair, head and count. Ties
// keep the order of a classic array heap: sift-up stops at an equal parent,
// sift-down prefers the left child on equal keys. Items are handled one at a
// time: the sequencer walks the heap one level at a time through a storage
// array with registered reads. At the default capacity of 64, a push walks at
// most six levels and a pop at most five. A finished result waits in an output
// register and the next item is accepted meanwhile; the sequencer only holds
// in its last state while an earlier result has not yet been taken.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic signed [31:0] priority_req_i,
  input  logic [31:0]       payload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [31:0]       popped_payload_o,
  output logic signed [31:0] popped_priority_o,
  output logic              head_valid_o,
  output logic [31:0]       head_payload_o,
  output logic signed [31:0] head_priority_o,
  output logic [CNT_W-1:0]  entry_count_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and datapath
  bmhq_dpath #(
    .CAPACITY (CAPACITY),
    .IDX_W    ($clog2(CAPACITY)),
    .CNT_W    (CNT_W)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .priority_req_i    (priority_req_i),
    .payload_i         (payload_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .popped_payload_o  (popped_payload_o),
    .popped_priority_o (popped_priority_o),
    .head_valid_o      (head_valid_o),
    .head_payload_o    (head_payload_o),
    .head_priority_o   (head_priority_o),
    .entry_count_o     (entry_count_o)
  );

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for the heap queue: decodes an item, steps sift-up or sift-down
// one level at a time, reads the head and hands the result to the output.
// ----------------------------------------------------------------------------
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_DONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.set_status = 1'b1;
          case (func_i)
            FUNC_PUSH: begin
              if (stat_i.full) begin
                cmd_o.status = ST_FULL;
                state_d      = S_HEAD_RD;
              end else begin
                cmd_o.cap_push = 1'b1;
                state_d        = S_UP_CHK;
              end
            end
            FUNC_POP: begin
              if (stat_i.empty) begin
                cmd_o.status = ST_EMPTY;
                state_d      = S_RESULT;
              end else begin
                cmd_o.rd_ends = 1'b1;
                state_d       = S_DN_TAKE;
              end
            end
            FUNC_CLEAR: begin
              cmd_o.clr_fill = 1'b1;
              state_d        = S_RESULT;
            end
            default: begin
              // unused code: no change, just report
              state_d = stat_i.empty ? S_RESULT : S_HEAD_RD;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (stat_i.n_root) begin
          cmd_o.place = 1'b1;
          state_d     = S_HEAD_RD;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_go) begin
          cmd_o.up_step = 1'b1;
          state_d       = S_UP_CHK;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_HEAD_RD;
        end
      end
      S_DN_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat_i.dn_more) begin
          cmd_o.rd_kids = 1'b1;
          state_d       = S_DN_CMP;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_HEAD_RD;
        end
      end
      S_DN_CMP: begin
        if (stat_i.dn_go) begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_CHK;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd_o.rd_root = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bmhq_dpath.sv =====
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap storage (two read ports, one write port, registered reads), entry
// count, moving-entry and popped-entry registers, compares and the result
// register.
// ----------------------------------------------------------------------------
module bmhq_dpath
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [31:0]       priority_req_i,
  input  logic [31:0]       payload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [31:0]       popped_payload_o,
  output logic [31:0]       popped_priority_o,
  output logic              head_valid_o,
  output logic [31:0]       head_payload_o,
  output logic [31:0]       head_priority_o,
  output logic [CNT_W-1:0]  entry_count_o
);

  // 1-based slot number to memory address; out-of-range slots fold to 0
  function automatic logic [IDX_W-1:0] slot_addr(input logic [CNT_W-1:0] s);
    logic [CNT_W-1:0] z;
    z = s - CNT_W'(1);
    return (z >= CNT_W'(CAPACITY)) ? '0 : z[IDX_W-1:0];
  endfunction

  entry_t           mem_q [CAPACITY];
  entry_t           rd_a_q, rd_b_q;
  entry_t           mov_q, pop_q, child;
  entry_t           wdata;
  logic [CNT_W-1:0] fill_q, n_q;
  logic [CNT_W-1:0] kid_slot, child_slot;
  logic [1:0]       status_q;
  logic             rd_en_a, rd_en_b, we, use_r;
  logic [IDX_W-1:0] addr_a, addr_b, waddr;
  logic             out_valid_q, head_valid_q;
  logic [1:0]       out_status_q;
  entry_t           out_pop_q, out_head_q;
  logic [CNT_W-1:0] out_count_q;

  // Child selection for sift-down: right only when left is strictly smaller
  always_comb begin
    kid_slot   = {n_q[CNT_W-2:0], 1'b0};
    use_r      = (kid_slot < fill_q) && (rd_a_q.pri < rd_b_q.pri);
    child      = use_r ? rd_b_q : rd_a_q;
    child_slot = use_r ? kid_slot + CNT_W'(1) : kid_slot;
  end

  // Status back to the controller
  always_comb begin
    stat_o.full     = (fill_q >= CNT_W'(CAPACITY));
    stat_o.empty    = (fill_q == '0);
    stat_o.n_root   = (n_q == CNT_W'(1));
    stat_o.up_go    = (rd_a_q.pri < mov_q.pri);
    stat_o.dn_more  = (n_q <= (fill_q >> 1));
    stat_o.dn_go    = !(mov_q.pri > child.pri);
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Memory port addressing
  always_comb begin
    rd_en_a = cmd_i.rd_parent | cmd_i.rd_ends | cmd_i.rd_kids | cmd_i.rd_root;
    rd_en_b = cmd_i.rd_ends | cmd_i.rd_kids;
    if (cmd_i.rd_parent) begin
      addr_a = slot_addr(n_q >> 1);
    end else if (cmd_i.rd_kids) begin
      addr_a = slot_addr(kid_slot);
    end else begin
      addr_a = slot_addr(CNT_W'(1));
    end
    addr_b = cmd_i.rd_kids ? slot_addr(kid_slot + CNT_W'(1)) : slot_addr(fill_q);
    we     = cmd_i.up_step | cmd_i.dn_step | cmd_i.place;
    waddr  = slot_addr(n_q);
    if (cmd_i.up_step) begin
      wdata = rd_a_q;
    end else if (cmd_i.dn_step) begin
      wdata = child;
    end else begin
      wdata = mov_q;
    end
  end

  // Heap storage with registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_a) begin
      rd_a_q <= mem_q[addr_a];
    end
    if (rd_en_b) begin
      rd_b_q <= mem_q[addr_b];
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.clr_fill) begin
      fill_q <= '0;
    end else if (cmd_i.cap_push) begin
      fill_q <= fill_q + CNT_W'(1);
    end else if (cmd_i.take) begin
      fill_q <= fill_q - CNT_W'(1);
    end
  end

  // Walk slot, moving entry, popped entry, status
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_push) begin
      n_q   <= fill_q + CNT_W'(1);
      mov_q <= '{pri: priority_req_i, pay: payload_i};
    end else if (cmd_i.up_step) begin
      n_q <= n_q >> 1;
    end else if (cmd_i.take) begin
      n_q   <= CNT_W'(1);
      mov_q <= rd_b_q;
    end else if (cmd_i.dn_step) begin
      n_q <= child_slot;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
      pop_q    <= '0;
    end else if (cmd_i.take) begin
      pop_q <= rd_a_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_pop_q    <= pop_q;
      head_valid_q <= (fill_q != '0);
      out_head_q   <= (fill_q != '0) ? rd_a_q : '0;
      out_count_q  <= fill_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign popped_payload_o  = out_pop_q.pay;
  assign popped_priority_o = out_pop_q.pri;
  assign head_valid_o      = head_valid_q;
  assign head_payload_o    = out_head_q.pay;
  assign head_priority_o   = out_head_q.pri;
  assign entry_count_o     = out_count_q;

`ifndef NO_ASSERTIONS
  // count never passes capacity
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // result register is never overwritten while still held
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before taken");

  // children are only read when the left child exists
  a_kids_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_kids |-> (n_q != '0) && (n_q <= (fill_q >> 1)))
    else $error("child read outside heap");

  // after a push the count is nonzero and the walk slot is the new last slot
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap_push |=> (fill_q != '0) && (n_q == fill_q))
    else $error("push slot does not match new count");
`endif

endmodule
